// ----- rtl/rfc_pkg.sv -----
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types and constants of the rational frame clock.
// ----------------------------------------------------------------------------
package rfc_pkg;

    localparam int unsigned WW = 128;

    localparam logic [WW-1:0] NS_PER_SECOND = 128'd1000000000;

    localparam logic [1:0] MODE_READ = 2'd0;
    localparam logic [1:0] MODE_SET  = 2'd1;
    localparam logic [1:0] MODE_ADD  = 2'd2;

    localparam logic [1:0] CM_MONO  = 2'd0;
    localparam logic [1:0] CM_SCRUB = 2'd1;
    localparam logic [1:0] CM_AUDIO = 2'd2;

    localparam logic [2:0] REG_CLOCK_MODE  = 3'd0;
    localparam logic [2:0] REG_BASE_FRAME  = 3'd1;
    localparam logic [2:0] REG_BASE_PNUM   = 3'd2;
    localparam logic [2:0] REG_BASE_PDEN   = 3'd3;
    localparam logic [2:0] REG_FPS_NUM     = 3'd4;
    localparam logic [2:0] REG_FPS_DEN     = 3'd5;
    localparam logic [2:0] REG_SAMPLE_RATE = 3'd6;
    localparam logic [2:0] REG_SAMPLE_OFF  = 3'd7;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_ucmd;

    typedef enum logic [4:0] {
        S_IDLE,
        S_BMUL,
        S_DMUL1,
        S_DMUL2,
        S_GCHK,
        S_GDIV,
        S_SDIV1,
        S_SDIV2,
        S_M1,
        S_M2,
        S_M3,
        S_NORM,
        S_NDIV,
        S_RDIV1,
        S_RDIV2,
        S_OUT
    } t_state;

endpackage

// ----- rtl/rfc_muldiv.sv -----
// ----------------------------------------------------------------------------
// rfc_muldiv
// Bit-serial 128-bit unit: wrapping multiply or unsigned divide with remainder.
// ----------------------------------------------------------------------------
module rfc_muldiv (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rfc_pkg::t_ucmd        i_cmd,
    input  logic [rfc_pkg::WW-1:0] i_x,
    input  logic [rfc_pkg::WW-1:0] i_y,
    output logic                  o_done,
    output logic [rfc_pkg::WW-1:0] o_lo,
    output logic [rfc_pkg::WW-1:0] o_rem
);
    import rfc_pkg::*;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    t_op           r_op, n_op;
    logic [6:0]    r_cnt, n_cnt;
    logic [WW-1:0] r_p, n_p;
    logic [WW-1:0] r_s, n_s;
    logic [WW-1:0] r_t, n_t;
    logic [WW-1:0] sh;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_p    = r_p;
        n_s    = r_s;
        n_t    = r_t;
        sh     = {r_p[WW-2:0], r_s[WW-1]};
        if (!r_busy) begin
            if (i_cmd.start) begin
                n_busy = 1'b1;
                n_op   = i_cmd.op;
                n_cnt  = '0;
                n_p    = '0;
                n_s    = i_x;
                n_t    = i_y;
            end
        end else begin
            case (r_op)
                OP_MUL: begin
                    if (r_t[0]) begin
                        n_p = r_p + r_s;
                    end
                    n_s = {r_s[WW-2:0], 1'b0};
                    n_t = {1'b0, r_t[WW-1:1]};
                end
                OP_DIV: begin
                    if (r_p[WW-1] || sh >= r_t) begin
                        n_p = sh - r_t;
                        n_s = {r_s[WW-2:0], 1'b1};
                    end else begin
                        n_p = sh;
                        n_s = {r_s[WW-2:0], 1'b0};
                    end
                end
                default: n_p = r_p;
            endcase
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd127) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_op  <= n_op;
        r_cnt <= n_cnt;
        r_p   <= n_p;
        r_s   <= n_s;
        r_t   <= n_t;
    end

    assign o_done = r_done;
    assign o_lo   = (r_op == OP_MUL) ? r_p : r_s;
    assign o_rem  = r_p;

endmodule

// ----- rtl/rational_frame_clock.sv -----
// ----------------------------------------------------------------------------
// rational_frame_clock
// Exact rational frame position from elapsed time, scrub base or audio count.
//
//  channel   signals                      beat
//  s_axis    tvalid tready tdata tuser    one request (read, set, add)
//  m_axis    tvalid tready tdata tuser    one frame position per read
//  cfg       valid ready index data       one register write
//
// Set and add requests update the played count as they are accepted. A read
// runs multiply and divide steps (start, shifts, done) on one shared
// bit-serial unit: eleven steps, plus one division per Euclid step in each
// of two gcd passes. A scrub read runs four steps and one gcd pass.
// Reset is synchronous; registers return to their defaults, played count 0.
// s_axis_tready stays low from a read until its result beat is taken.
// ----------------------------------------------------------------------------
module rational_frame_clock (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,  // elapsed[63:0], sample_count[127:64]
    input  logic [1:0]    s_axis_tuser,  // mode[1:0]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [191:0]  m_axis_tdata,  // frame[63:0], ph_num[126:64],
                                         // ph_den[189:127], zero[191:190]
    output logic [1:0]    m_axis_tuser,  // result_mode[1:0]
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_data
);
    import rfc_pkg::*;

    function automatic logic [WW-1:0] f_abs(input logic [WW-1:0] v);
        f_abs = v[WW-1] ? (~v + 1'b1) : v;
    endfunction

    t_state r_state, n_state;
    logic   r_pend, n_pend;
    logic   r_phase, n_phase;
    logic [1:0]  r_cmode, r_rmode, n_rmode;
    logic [63:0] r_fr, r_soff, r_played, n_played, r_e, n_e;
    logic [31:0] r_pnum, r_pden, r_fnum, r_fden, r_srate;
    logic [WW-1:0] r_bn, n_bn, r_bd, n_bd, r_dn, n_dn, r_dd, n_dd;
    logic [WW-1:0] r_n, n_n, r_d, n_d, r_q, n_q, r_r, n_r;
    logic [WW-1:0] r_ga, n_ga, r_gb, n_gb;
    logic [63:0] r_ofr, n_ofr;
    logic [62:0] r_opn, n_opn, r_opd, n_opd;

    t_ucmd         ucmd;
    logic [WW-1:0] ux, uy, u_lo, u_rem;
    logic          u_done;
    logic [63:0]   audible;

    rfc_muldiv u_muldiv (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (ucmd),
        .i_x    (ux),
        .i_y    (uy),
        .o_done (u_done),
        .o_lo   (u_lo),
        .o_rem  (u_rem)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {2'b00, r_opd, r_opn, r_ofr};
    assign m_axis_tuser  = r_rmode;
    assign audible       = r_played - r_soff;

    always_comb begin
        n_state  = r_state;
        n_pend   = r_pend;
        n_phase  = r_phase;
        n_rmode  = r_rmode;
        n_played = r_played;
        n_e      = r_e;
        n_bn = r_bn; n_bd = r_bd; n_dn = r_dn; n_dd = r_dd;
        n_n  = r_n;  n_d  = r_d;  n_q  = r_q;  n_r  = r_r;
        n_ga = r_ga; n_gb = r_gb;
        n_ofr = r_ofr; n_opn = r_opn; n_opd = r_opd;
        ucmd.start = 1'b0;
        ucmd.op    = OP_MUL;
        ux = '0;
        uy = '0;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    case (s_axis_tuser)
                        MODE_SET: n_played = s_axis_tdata[127:64];
                        MODE_ADD: n_played = r_played + s_axis_tdata[127:64];
                        MODE_READ: begin
                            n_e  = s_axis_tdata[63:0];
                            n_bd = {96'd0, (r_pden == 32'd0) ? 32'd1 : r_pden};
                            n_rmode = (r_cmode == CM_SCRUB) ? CM_SCRUB :
                                      (r_cmode == CM_AUDIO) ? CM_AUDIO : CM_MONO;
                            n_state = S_BMUL;
                        end
                        default: n_played = r_played;
                    endcase
                end
            end
            S_BMUL: begin
                ux = {{64{r_fr[63]}}, r_fr};
                uy = r_bd;
                if (u_done) begin
                    n_bn = u_lo + {{96{r_pnum[31]}}, r_pnum};
                    if (r_rmode == CM_SCRUB) begin
                        n_n = n_bn;
                        n_d = r_bd;
                        n_state = S_NORM;
                    end else begin
                        n_state = S_DMUL1;
                    end
                end
            end
            S_DMUL1: begin
                if (r_rmode == CM_AUDIO) begin
                    ux = {{64{audible[63]}}, audible};
                end else begin
                    ux = {64'd0, r_e[63] ? 64'd0 : r_e};
                end
                uy = {96'd0, r_fnum};
                if (u_done) begin
                    n_dn = u_lo;
                    n_state = S_DMUL2;
                end
            end
            S_DMUL2: begin
                ux = (r_rmode == CM_AUDIO) ? {96'd0, r_srate} : NS_PER_SECOND;
                uy = {96'd0, r_fden};
                if (u_done) begin
                    n_dd = u_lo;
                    n_ga = f_abs(r_dn);
                    n_gb = f_abs(u_lo);
                    n_phase = 1'b0;
                    n_state = S_GCHK;
                end
            end
            S_GCHK: begin
                if (r_gb == '0) begin
                    n_ga = (r_ga == '0) ? {{(WW-1){1'b0}}, 1'b1} : r_ga;
                    n_state = r_phase ? S_RDIV1 : S_SDIV1;
                end else begin
                    n_state = S_GDIV;
                end
            end
            S_GDIV: begin
                ucmd.op = OP_DIV;
                ux = r_ga;
                uy = r_gb;
                if (u_done) begin
                    n_ga = r_gb;
                    n_gb = u_rem;
                    n_state = S_GCHK;
                end
            end
            S_SDIV1: begin
                ucmd.op = OP_DIV;
                ux = f_abs(r_dn);
                uy = r_ga;
                if (u_done) begin
                    n_dn = r_dn[WW-1] ? (~u_lo + 1'b1) : u_lo;
                    n_state = S_SDIV2;
                end
            end
            S_SDIV2: begin
                ucmd.op = OP_DIV;
                ux = f_abs(r_dd);
                uy = r_ga;
                if (u_done) begin
                    n_dd = r_dd[WW-1] ? (~u_lo + 1'b1) : u_lo;
                    n_state = S_M1;
                end
            end
            S_M1: begin
                ux = r_bn;
                uy = r_dd;
                if (u_done) begin
                    n_n = u_lo;
                    n_state = S_M2;
                end
            end
            S_M2: begin
                ux = r_dn;
                uy = r_bd;
                if (u_done) begin
                    n_n = r_n + u_lo;
                    n_state = S_M3;
                end
            end
            S_M3: begin
                ux = r_bd;
                uy = r_dd;
                if (u_done) begin
                    n_d = u_lo;
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (r_d == '0 || r_d[WW-1]) begin
                    n_ofr = '0;
                    n_opn = '0;
                    n_opd = 63'd1;
                    n_state = S_OUT;
                end else begin
                    n_state = S_NDIV;
                end
            end
            S_NDIV: begin
                ucmd.op = OP_DIV;
                ux = f_abs(r_n);
                uy = r_d;
                if (u_done) begin
                    if (r_n[WW-1]) begin
                        if (u_rem != '0) begin
                            n_q = ~u_lo;
                            n_r = r_d - u_rem;
                        end else begin
                            n_q = ~u_lo + 1'b1;
                            n_r = '0;
                        end
                    end else begin
                        n_q = u_lo;
                        n_r = u_rem;
                    end
                    n_ga = n_r;
                    n_gb = r_d;
                    n_phase = 1'b1;
                    n_state = S_GCHK;
                end
            end
            S_RDIV1: begin
                ucmd.op = OP_DIV;
                ux = r_r;
                uy = r_ga;
                if (u_done) begin
                    n_r = u_lo;
                    n_state = S_RDIV2;
                end
            end
            S_RDIV2: begin
                ucmd.op = OP_DIV;
                ux = r_d;
                uy = r_ga;
                if (u_done) begin
                    n_ofr = r_q[63:0];
                    n_opn = r_r[62:0];
                    n_opd = u_lo[62:0];
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        case (r_state)
            S_BMUL, S_DMUL1, S_DMUL2, S_GDIV, S_SDIV1, S_SDIV2, S_M1, S_M2, S_M3,
            S_NDIV, S_RDIV1, S_RDIV2: begin
                ucmd.start = !r_pend;
                if (!r_pend) begin
                    n_pend = 1'b1;
                end else if (u_done) begin
                    n_pend = 1'b0;
                end
            end
            default: n_pend = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend   <= 1'b0;
            r_played <= '0;
            r_cmode  <= CM_MONO;
            r_fr     <= '0;
            r_pnum   <= '0;
            r_pden   <= 32'd1;
            r_fnum   <= 32'd30;
            r_fden   <= 32'd1;
            r_srate  <= 32'd48000;
            r_soff   <= '0;
        end else begin
            r_state  <= n_state;
            r_pend   <= n_pend;
            r_played <= n_played;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_CLOCK_MODE:  r_cmode <= i_cfg_data[1:0];
                    REG_BASE_FRAME:  r_fr    <= i_cfg_data;
                    REG_BASE_PNUM:   r_pnum  <= i_cfg_data[31:0];
                    REG_BASE_PDEN:   r_pden  <= i_cfg_data[31:0];
                    REG_FPS_NUM:     r_fnum  <= i_cfg_data[31:0];
                    REG_FPS_DEN:     r_fden  <= i_cfg_data[31:0];
                    REG_SAMPLE_RATE: r_srate <= i_cfg_data[31:0];
                    REG_SAMPLE_OFF:  r_soff  <= i_cfg_data;
                    default:         r_soff  <= r_soff;
                endcase
            end
        end
        r_phase <= n_phase;
        r_rmode <= n_rmode;
        r_e  <= n_e;
        r_bn <= n_bn; r_bd <= n_bd; r_dn <= n_dn; r_dd <= n_dd;
        r_n  <= n_n;  r_d  <= n_d;  r_q  <= n_q;  r_r  <= n_r;
        r_ga <= n_ga; r_gb <= n_gb;
        r_ofr <= n_ofr; r_opn <= n_opn; r_opd <= n_opd;
    end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rational frame clock. Requests go in on the
// slave stream with random gaps; every read is predicted with exact 128-bit
// rational arithmetic and each result beat is compared with the oldest
// prediction. Registers change only while the block is idle, across settings
// that include zero denominators, the unused clock mode and 64-bit extremes.
// ----------------------------------------------------------------------------
module tb_top;
    import rfc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_NONE  = 2'd3;
    localparam logic [1:0] CM_UNUSED  = 2'd3;
    localparam longint     CYCLE_CAP  = 300_000_000;
    localparam int         DRAIN_WAIT = 40;

    typedef logic [127:0] w_t;

    typedef struct packed {
        logic [63:0] frame;
        logic [62:0] pnum;
        logic [62:0] pden;
        logic [1:0]  rmode;
    } pos_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;  // elapsed[63:0], sample_count[127:64]
    logic [1:0]   s_axis_tuser = '0;  // mode[1:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [191:0] m_axis_tdata;       // frame, ph_num, ph_den, zero pad
    logic [1:0]   m_axis_tuser;       // result_mode[1:0]
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index = '0;
    logic [63:0]  i_cfg_data = '0;

    rational_frame_clock i_dut (.*);

    always #6 i_clk = ~i_clk;

    // predictor copy of registers and state
    logic [1:0]  clk_mode;
    logic [63:0] seek_frame, smp_offset, played;
    logic [31:0] base_pnum, base_pden, fps_n, fps_d, smp_rate;

    pos_t   positions_due[$];
    int     fails = 0;
    int     reads_sent = 0;
    int     positions_seen = 0;
    int     updates_sent = 0;
    int     cfg_writes = 0;
    int     rx_stall = 0;
    bit     no_idle = 0;
    longint cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("rational_frame_clock test failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 4);
        return $urandom_range(10, 200);
    endfunction

    function automatic w_t sx64(logic [63:0] v);
        return {{64{v[63]}}, v};
    endfunction

    function automatic w_t mag(w_t a);
        return a[127] ? -a : a;
    endfunction

    function automatic w_t gcd_w(w_t a, w_t b);
        w_t t;
        a = mag(a);
        b = mag(b);
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return (a == 0) ? w_t'(1) : a;
    endfunction

    function automatic w_t sdiv_w(w_t n, w_t d);
        w_t q;
        q = mag(n) / d;
        return n[127] ? -q : q;
    endfunction

    function automatic pos_t floor_reduce(w_t num, w_t den, logic [1:0] rm);
        pos_t p;
        w_t q, r, g;
        p.rmode = rm;
        if (den == 0 || den[127]) begin
            p.frame = '0;
            p.pnum = '0;
            p.pden = 63'd1;
            return p;
        end
        if (num[127]) begin
            q = -((-num) / den);
            r = (-num) % den;
            if (r != 0) begin
                q = q - 1;
                r = den - r;
            end
        end else begin
            q = num / den;
            r = num % den;
        end
        g = gcd_w(r, den);
        r = r / g;
        den = den / g;
        p.frame = q[63:0];
        p.pnum = r[62:0];
        p.pden = den[62:0];
        return p;
    endfunction

    function automatic pos_t add_rate(w_t bnum, w_t bden, w_t dnum, w_t dden,
                                      logic [1:0] rm);
        w_t g;
        g = gcd_w(dnum, dden);
        dnum = sdiv_w(dnum, g);
        dden = sdiv_w(dden, g);
        return floor_reduce(bnum * dden + dnum * bden, bden * dden, rm);
    endfunction

    function automatic pos_t frame_position(logic [63:0] elapsed);
        w_t bden, bnum;
        logic [63:0] e;
        bden = {96'b0, (base_pden != 0) ? base_pden : 32'd1};
        bnum = sx64(seek_frame) * bden + {{96{base_pnum[31]}}, base_pnum};
        case (clk_mode)
            CM_SCRUB: return floor_reduce(bnum, bden, CM_SCRUB);
            CM_AUDIO: return add_rate(bnum, bden,
                                      sx64(played - smp_offset) * {96'b0, fps_n},
                                      {96'b0, smp_rate} * {96'b0, fps_d}, CM_AUDIO);
            default: begin
                e = elapsed[63] ? 64'd0 : elapsed;
                return add_rate(bnum, bden, {64'b0, e} * {96'b0, fps_n},
                                NS_PER_SECOND * {96'b0, fps_d}, CM_MONO);
            end
        endcase
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        fails++;
        $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want,
                 positions_seen);
    endtask

    always @(posedge i_clk) begin
        pos_t want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                positions_seen++;
                if (positions_due.size() == 0) begin
                    report("unexpected beat", m_axis_tdata[63:0], '0);
                end else begin
                    want = positions_due.pop_front();
                    if (m_axis_tdata[63:0] !== want.frame)
                        report("frame", m_axis_tdata[63:0], want.frame);
                    if (m_axis_tdata[126:64] !== want.pnum)
                        report("ph_num", 64'(m_axis_tdata[126:64]), 64'(want.pnum));
                    if (m_axis_tdata[189:127] !== want.pden)
                        report("ph_den", 64'(m_axis_tdata[189:127]), 64'(want.pden));
                    if (m_axis_tdata[191:190] !== 2'b00)
                        report("pad", 64'(m_axis_tdata[191:190]), '0);
                    if (m_axis_tuser !== want.rmode)
                        report("result_mode", 64'(m_axis_tuser), 64'(want.rmode));
                end
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                rx_stall = pick_gap();
                m_axis_tready <= (rx_stall == 0);
                if (rx_stall > 0) rx_stall--;
            end
        end
    end

    task automatic send_item(logic [1:0] mode, logic [63:0] elapsed, logic [63:0] count);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= {count, elapsed};
        do @(posedge i_clk); while (!s_axis_tready);
        case (mode)
            MODE_READ: begin
                positions_due.push_back(frame_position(elapsed));
                reads_sent++;
            end
            MODE_SET: begin played = count; updates_sent++; end
            MODE_ADD: begin played = played + count; updates_sent++; end
            default: ;
        endcase
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (positions_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        cfg_writes++;
        case (idx)
            REG_CLOCK_MODE:  clk_mode = data[1:0];
            REG_BASE_FRAME:  seek_frame = data;
            REG_BASE_PNUM:   base_pnum = data[31:0];
            REG_BASE_PDEN:   base_pden = data[31:0];
            REG_FPS_NUM:     fps_n = data[31:0];
            REG_FPS_DEN:     fps_d = data[31:0];
            REG_SAMPLE_RATE: smp_rate = data[31:0];
            default:         smp_offset = data;
        endcase
    endtask

    task automatic write_all(logic [1:0] cm, logic [63:0] bf, logic [63:0] pn,
                             logic [63:0] pd, logic [63:0] fn, logic [63:0] fd,
                             logic [63:0] sr, logic [63:0] so);
        write_reg(REG_CLOCK_MODE, {62'b0, cm});
        write_reg(REG_BASE_FRAME, bf);
        write_reg(REG_BASE_PNUM, pn);
        write_reg(REG_BASE_PDEN, pd);
        write_reg(REG_FPS_NUM, fn);
        write_reg(REG_FPS_DEN, fd);
        write_reg(REG_SAMPLE_RATE, sr);
        write_reg(REG_SAMPLE_OFF, so);
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 5))
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(0, 100000));
            2: return -64'($urandom_range(0, 100000));
            3: return $urandom_range(0, 1) ? 64'h7FFF_FFFF_FFFF_FFFF
                                           : 64'h8000_0000_0000_0000;
            4: return 64'($urandom) * 64'd1000;
            default: return {32'b0, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] rand32();
        case ($urandom_range(0, 4))
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(1, 120));
            2: return 64'($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1);
            default: return 64'($urandom_range(1, 96000));
        endcase
    endfunction

    task automatic test_defaults();
        clk_mode = CM_MONO; seek_frame = '0; base_pnum = '0; base_pden = 32'd1;
        fps_n = 32'd30; fps_d = 32'd1; smp_rate = 32'd48000; smp_offset = '0;
        played = '0;
        send_item(MODE_READ, 64'd1_500_000_000, '0);
        send_item(MODE_READ, 64'd33_333_333, '0);
        settle();
    endtask

    task automatic test_directed();
        write_all(CM_MONO, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF, 64'hFFFF_FFFF,
                  64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'h8000_0000_0000_0000);
        send_item(MODE_READ, 64'h7FFF_FFFF_FFFF_FFFF, '0);
        send_item(MODE_READ, 64'h8000_0000_0000_0000, '0);
        send_item(MODE_READ, 64'hFFFF_FFFF_FFFF_FFFF, '0);
        send_item(MODE_READ, '0, '0);
        settle();
        write_all(CM_AUDIO, 64'h8000_0000_0000_0000, 64'h8000_0000, 64'd0,
                  64'd24000, 64'd1001, 64'd48000, 64'd480);
        send_item(MODE_SET, '1, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(MODE_READ, '0, '0);
        send_item(MODE_ADD, '0, 64'd1);
        send_item(MODE_READ, '1, '1);
        send_item(MODE_NONE, '1, '1);
        send_item(MODE_READ, '0, '0);
        send_item(MODE_SET, '0, '0);
        send_item(MODE_READ, '0, '0);
        settle();
        write_reg(REG_SAMPLE_RATE, '0);
        send_item(MODE_READ, '0, '0);
        settle();
        write_reg(REG_FPS_NUM, '0);
        write_reg(REG_SAMPLE_RATE, 64'd44100);
        send_item(MODE_READ, '0, '0);
        settle();
        write_reg(REG_CLOCK_MODE, {62'b0, CM_SCRUB});
        write_reg(REG_BASE_PNUM, 64'hFFFF_FFFF_FFFF_FFFD);
        write_reg(REG_BASE_PDEN, 64'd6);
        send_item(MODE_READ, '0, '0);
        settle();
        write_reg(REG_CLOCK_MODE, {62'b0, CM_UNUSED});
        write_reg(REG_FPS_NUM, 64'd60);
        send_item(MODE_READ, 64'd2_000_000_001, '0);
        settle();
        write_reg(REG_FPS_DEN, '0);
        write_reg(REG_CLOCK_MODE, {62'b0, CM_MONO});
        send_item(MODE_READ, 64'd5, '0);
        settle();
    endtask

    task automatic test_random(int phases, int per_phase);
        logic [1:0] m;
        int r;
        for (int ph = 0; ph < phases; ph++) begin
            no_idle = (ph % 4 == 3);
            write_all(2'($urandom_range(0, 3)), rand64(), rand32(), rand32(),
                      rand32(), rand32(), rand32(), rand64());
            for (int k = 0; k < per_phase; k++) begin
                r = $urandom_range(0, 99);
                m = (r < 40) ? MODE_READ : (r < 65) ? MODE_SET
                  : (r < 92) ? MODE_ADD : MODE_NONE;
                send_item(m, rand64(), rand64());
            end
            settle();
        end
        no_idle = 0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_directed();
        test_random(10, 150);
        settle();
        $display("Covered %0d reads, %0d count updates, %0d register writes;",
                 reads_sent, updates_sent, cfg_writes);
        $display("%0d frame positions checked with %0d mismatches.", positions_seen, fails);
        if (fails == 0)
            $display("rational_frame_clock test passed");
        else
            $display("rational_frame_clock test failed");
        $finish;
    end
endmodule
